// ===== rtl/core/pmu_pkg.sv =====
// Shared types, constants and helpers for the particle motion update unit.
// Depends on nothing; every other file of the block imports it.
package pmu_pkg;

  // Motion mode codes carried in each item.
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;
  localparam logic [1:0] MODE_SEEK   = 2'd2;

  // Edge mode codes.
  localparam logic [1:0] EDGE_NONE   = 2'd0;
  localparam logic [1:0] EDGE_BOUNCE = 2'd1;
  localparam logic [1:0] EDGE_WRAP   = 2'd2;
  localparam logic [1:0] EDGE_KILL   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_EDGE_MODE     = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED     = 3'd1;
  localparam logic [2:0] CFG_ACCEL_SCALE   = 3'd2;
  localparam logic [2:0] CFG_JITTER_AMOUNT = 3'd3;
  localparam logic [2:0] CFG_WORLD_X       = 3'd4;
  localparam logic [2:0] CFG_WORLD_Y       = 3'd5;
  localparam logic [2:0] CFG_WORLD_WIDTH   = 3'd6;
  localparam logic [2:0] CFG_WORLD_HEIGHT  = 3'd7;

  // Square root: radicand width, root width, one root bit per stage.
  localparam int SQ_W     = 52;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int SQRT_LAT = ROOT_W;

  // Divider: numerator width, one quotient bit per stage.
  localparam int NUM_W   = 40;
  localparam int DIV_LAT = 17;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] home_x;
    logic signed [15:0] home_y;
    logic        [13:0] radius;
    logic               alive_in;
    logic        [1:0]  motion_mode;
    logic signed [15:0] rand_x;
    logic signed [15:0] rand_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic               alive_out;
  } result_t;

  typedef struct packed {
    logic        [1:0]  edge_mode;
    logic        [14:0] max_speed;
    logic        [15:0] accel_scale;
    logic        [14:0] jitter_amount;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] world_width;
    logic signed [15:0] world_height;
  } cfg_t;

  // Item context through the acceleration path.
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic        [13:0] rad;
    logic               alive;
    logic        [1:0]  mode;
    logic               dneg_x;
    logic               dneg_y;
    logic               dzero;
    logic signed [17:0] jx;
    logic signed [17:0] jy;
    logic        [36:0] nx;
    logic        [36:0] ny;
  } motion_ctx_t;

  // Item context through the speed limit path.
  typedef struct packed {
    logic signed [15:0]     px;
    logic signed [15:0]     py;
    logic signed [17:0]     vx;
    logic signed [17:0]     vy;
    logic        [13:0]     rad;
    logic                   alive;
    logic                   moving;
    logic                   limit;
    logic        [NUM_W-1:0] nx;
    logic        [NUM_W-1:0] ny;
  } vel_ctx_t;

  // Moved particle handed to the edge stage.
  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic        [13:0] rad;
    logic               alive;
  } edge_in_t;

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    logic [15:0] r;
    if (v > 19'sd32767) r = 16'h7fff;
    else if (v < -19'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/pmu_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on pmu_pkg for widths and latency.
module pmu_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pmu_pkg::SQ_W-1:0]   in_val,
  output logic                       out_valid,
  output logic [pmu_pkg::ROOT_W-1:0] root
);
  import pmu_pkg::*;

  logic [SQ_W-1:0] n_q [SQRT_LAT];
  logic [SQ_W-1:0] r_q [SQRT_LAT];
  logic            v_q [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_LAT - 1 - i));
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] trial;
    logic            v_in;

    if (i == 0) begin : g_first
      assign n_in = in_val;
      assign r_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) v_q[i] <= 1'b0;
      else v_q[i] <= v_in;
      if (n_in >= trial) begin
        n_q[i] <= n_in - trial;
        r_q[i] <= (r_in >> 1) + BIT;
      end else begin
        n_q[i] <= n_in;
        r_q[i] <= r_in >> 1;
      end
    end
  end

  assign out_valid = v_q[SQRT_LAT-1];
  assign root      = r_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/pmu_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on pmu_pkg; the caller keeps the quotient below 2**DIV_LAT.
module pmu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pmu_pkg::NUM_W-1:0]  num,
  input  logic [pmu_pkg::ROOT_W-1:0] den,
  output logic                       out_valid,
  output logic [pmu_pkg::DIV_LAT-1:0] quot
);
  import pmu_pkg::*;

  localparam int TW = ROOT_W + DIV_LAT;

  logic [NUM_W-1:0]   rem_q [DIV_LAT];
  logic [ROOT_W-1:0]  den_q [DIV_LAT];
  logic [DIV_LAT-1:0] q_q   [DIV_LAT];
  logic               v_q   [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    localparam int SH = DIV_LAT - 1 - k;
    logic [NUM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  den_in;
    logic [DIV_LAT-1:0] q_in;
    logic               v_in;
    logic [TW-1:0]      shifted;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = q_q[k-1];
      assign v_in   = v_q[k-1];
    end

    assign shifted = TW'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (rst) v_q[k] <= 1'b0;
      else v_q[k] <= v_in;
      den_q[k] <= den_in;
      if (TW'(rem_in) >= shifted) begin
        rem_q[k] <= rem_in - shifted[NUM_W-1:0];
        q_q[k]   <= q_in | (DIV_LAT'(1) << SH);
      end else begin
        rem_q[k] <= rem_in;
        q_q[k]   <= q_in;
      end
    end
  end

  assign out_valid = v_q[DIV_LAT-1];
  assign quot      = q_q[DIV_LAT-1];

endmodule

// ===== rtl/core/pmu_edge.sv =====
// Final stage: world edge handling (bounce, wrap, kill) and output saturation.
// Depends on pmu_pkg for the item, config and result types.
module pmu_edge (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pmu_pkg::edge_in_t in_item,
  input  pmu_pkg::cfg_t     cfg,
  output logic              done,
  output pmu_pkg::result_t  result
);
  import pmu_pkg::*;

  logic signed [18:0] px, py, vx, vy;
  logic signed [18:0] rad, half;
  logic signed [18:0] lo_x, hi_x, lo_y, hi_y;
  logic               alive;

  always_comb begin
    px    = {{2{in_item.px[16]}}, in_item.px};
    py    = {{2{in_item.py[16]}}, in_item.py};
    vx    = {{3{in_item.vx[15]}}, in_item.vx};
    vy    = {{3{in_item.vy[15]}}, in_item.vy};
    rad   = {5'b0, in_item.rad};
    half  = {6'b0, in_item.rad[13:1]};
    alive = in_item.alive;
    lo_x  = {{3{cfg.world_x[15]}}, cfg.world_x} + rad;
    hi_x  = {{3{cfg.world_width[15]}}, cfg.world_width} - rad;
    lo_y  = {{3{cfg.world_y[15]}}, cfg.world_y} + rad;
    hi_y  = {{3{cfg.world_height[15]}}, cfg.world_height} - rad;
    case (cfg.edge_mode)
      EDGE_BOUNCE: begin
        if (px < lo_x) begin
          vx = -vx;
          px = lo_x;
        end
        if (px > hi_x) begin
          vx = -vx;
          px = hi_x;
        end
        if (py < lo_y) begin
          vy = -vy;
          py = lo_y;
        end
        if (py > hi_y) begin
          vy = -vy;
          py = hi_y;
        end
      end
      EDGE_WRAP: begin
        lo_x = {{3{cfg.world_x[15]}}, cfg.world_x} - half;
        hi_x = {{3{cfg.world_width[15]}}, cfg.world_width} + half;
        lo_y = {{3{cfg.world_y[15]}}, cfg.world_y} - half;
        hi_y = {{3{cfg.world_height[15]}}, cfg.world_height} + half;
        if (px < lo_x) px = hi_x;
        if (px > hi_x) px = lo_x;
        if (py < lo_y) py = hi_y;
        if (py > hi_y) py = lo_y;
      end
      EDGE_KILL: begin
        if (px < lo_x || px > hi_x || py < lo_y || py > hi_y) alive = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= in_valid;
    result.new_pos_x <= sat16(px);
    result.new_pos_y <= sat16(py);
    result.new_vel_x <= sat16(vx);
    result.new_vel_y <= sat16(vy);
    result.alive_out <= alive;
  end

endmodule

// ===== rtl/core/particle_motion_update.sv =====
// Top level of the particle motion update unit: config registers and pipeline.
// Depends on pmu_pkg, pmu_sqrt, pmu_div and pmu_edge.
// Pipeline: registered stages A to H and the edge output register, with two
// square root pipelines (26 stages each) and two divider pipelines (17 each).
// Throughput: one item per cycle; busy stays low and the result side never stalls.
// Reset: synchronous; config registers return to their defaults, valid bits clear.
module particle_motion_update_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pmu_pkg::item_t   item,
  output logic             done,
  output pmu_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import pmu_pkg::*;

  // The pipeline never stalls, so an item is taken on every start.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers. Writes must arrive only while the pipeline is empty (the
  // user's duty; the block does not enforce it), so every stage reads them directly.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_mode     <= EDGE_WRAP;
      cfg.max_speed     <= 15'd4096;
      cfg.accel_scale   <= 16'd1311;
      cfg.jitter_amount <= 15'd614;
      cfg.world_x       <= 16'sd0;
      cfg.world_y       <= 16'sd0;
      cfg.world_width   <= 16'sd10240;
      cfg.world_height  <= 16'sd7680;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MODE:     cfg.edge_mode     <= cfg_data[1:0];
        CFG_MAX_SPEED:     cfg.max_speed     <= cfg_data[14:0];
        CFG_ACCEL_SCALE:   cfg.accel_scale   <= cfg_data;
        CFG_JITTER_AMOUNT: cfg.jitter_amount <= cfg_data[14:0];
        CFG_WORLD_X:       cfg.world_x       <= cfg_data;
        CFG_WORLD_Y:       cfg.world_y       <= cfg_data;
        CFG_WORLD_WIDTH:   cfg.world_width   <= cfg_data;
        CFG_WORLD_HEIGHT:  cfg.world_height  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage A: pick the steering vector. Random mode steers along the random
  // draw, seek mode along the vector from the position toward home.
  logic        [16:0] dx, dy;
  logic        [16:0] dabs_x, dabs_y;
  logic        [15:0] rabs_x, rabs_y;
  motion_ctx_t        ctx_a_next;

  always_comb begin
    if (item.motion_mode == MODE_SEEK) begin
      dx = {item.home_x[15], item.home_x} - {item.pos_x[15], item.pos_x};
      dy = {item.home_y[15], item.home_y} - {item.pos_y[15], item.pos_y};
    end else begin
      dx = {item.rand_x[15], item.rand_x};
      dy = {item.rand_y[15], item.rand_y};
    end
    dabs_x = dx[16] ? -dx : dx;
    dabs_y = dy[16] ? -dy : dy;
    rabs_x = item.rand_x[15] ? -item.rand_x : item.rand_x;
    rabs_y = item.rand_y[15] ? -item.rand_y : item.rand_y;
    ctx_a_next.px     = item.pos_x;
    ctx_a_next.py     = item.pos_y;
    ctx_a_next.vx     = item.vel_x;
    ctx_a_next.vy     = item.vel_y;
    ctx_a_next.rad    = item.radius;
    ctx_a_next.alive  = item.alive_in;
    ctx_a_next.mode   = item.motion_mode;
    ctx_a_next.dneg_x = dx[16];
    ctx_a_next.dneg_y = dy[16];
    ctx_a_next.dzero  = (dx == '0) && (dy == '0);
    ctx_a_next.jx     = '0;
    ctx_a_next.jy     = '0;
    ctx_a_next.nx     = '0;
    ctx_a_next.ny     = '0;
  end

  motion_ctx_t ctx_a;
  logic        a_valid;
  logic [16:0] a_dabs_x, a_dabs_y;
  logic [15:0] a_rabs_x, a_rabs_y;
  logic        a_rneg_x, a_rneg_y;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else a_valid <= accept;
    ctx_a    <= ctx_a_next;
    a_dabs_x <= dabs_x;
    a_dabs_y <= dabs_y;
    a_rabs_x <= rabs_x;
    a_rabs_y <= rabs_y;
    a_rneg_x <= item.rand_x[15];
    a_rneg_y <= item.rand_y[15];
  end

  // Stage B: squares for the vector length, scaled numerators for the
  // normalization and the seek-mode jitter (a shift by 14 after the product).
  logic [32:0] acc_x, acc_y;
  logic [30:0] jprod_x, jprod_y;
  logic [17:0] jmag_x, jmag_y;
  motion_ctx_t ctx_b_next;

  always_comb begin
    acc_x   = a_dabs_x * cfg.accel_scale;
    acc_y   = a_dabs_y * cfg.accel_scale;
    jprod_x = a_rabs_x * cfg.jitter_amount;
    jprod_y = a_rabs_y * cfg.jitter_amount;
    jmag_x  = {1'b0, jprod_x[30:14]};
    jmag_y  = {1'b0, jprod_y[30:14]};
    ctx_b_next    = ctx_a;
    ctx_b_next.nx = {acc_x, 4'b0};
    ctx_b_next.ny = {acc_y, 4'b0};
    if (ctx_a.mode == MODE_SEEK) begin
      ctx_b_next.jx = a_rneg_x ? -jmag_x : jmag_x;
      ctx_b_next.jy = a_rneg_y ? -jmag_y : jmag_y;
    end
  end

  motion_ctx_t ctx_b;
  logic        b_valid;
  logic [33:0] b_sq_x, b_sq_y;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else b_valid <= a_valid;
    ctx_b  <= ctx_b_next;
    b_sq_x <= a_dabs_x * a_dabs_x;
    b_sq_y <= a_dabs_y * a_dabs_y;
  end

  // Stage C: radicand for the length in Q.8, the sum of squares times 65536.
  logic [34:0]     b_sum;
  motion_ctx_t     ctx_c;
  logic            c_valid;
  logic [SQ_W-1:0] c_rad;

  assign b_sum = 35'(b_sq_x) + 35'(b_sq_y);

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else c_valid <= b_valid;
    ctx_c <= ctx_b;
    c_rad <= SQ_W'({b_sum, 16'b0});
  end

  // Steering vector length, then the two normalized acceleration axes.
  logic              sq1_valid;
  logic [ROOT_W-1:0] sq1_root;
  motion_ctx_t       ctx1_dl [SQRT_LAT];

  pmu_sqrt u_sqrt_steer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_val    (c_rad),
    .out_valid (sq1_valid),
    .root      (sq1_root)
  );

  always_ff @(posedge clk) begin
    ctx1_dl[0] <= ctx_c;
    for (int k = 1; k < SQRT_LAT; k++) ctx1_dl[k] <= ctx1_dl[k-1];
  end

  logic               div1_valid;
  logic               div1_valid_y;
  logic [DIV_LAT-1:0] q1_x, q1_y;
  motion_ctx_t        ctx2_dl [DIV_LAT];

  pmu_div u_div_accel_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq1_valid),
    .num       (NUM_W'(ctx1_dl[SQRT_LAT-1].nx)),
    .den       (sq1_root),
    .out_valid (div1_valid),
    .quot      (q1_x)
  );

  pmu_div u_div_accel_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq1_valid),
    .num       (NUM_W'(ctx1_dl[SQRT_LAT-1].ny)),
    .den       (sq1_root),
    .out_valid (div1_valid_y),
    .quot      (q1_y)
  );

  always_ff @(posedge clk) begin
    ctx2_dl[0] <= ctx1_dl[SQRT_LAT-1];
    for (int k = 1; k < DIV_LAT; k++) ctx2_dl[k] <= ctx2_dl[k-1];
  end

  // Stage D: new velocity = old velocity + acceleration + jitter. A zero
  // steering vector gives no acceleration. Static items keep their velocity.
  motion_ctx_t        ctx_m;
  logic        [17:0] ax, ay, qx, qy;
  logic        [17:0] vsum_x, vsum_y;
  logic               moving;
  vel_ctx_t           ctx_d_next;

  always_comb begin
    ctx_m  = ctx2_dl[DIV_LAT-1];
    qx     = {1'b0, q1_x};
    qy     = {1'b0, q1_y};
    ax     = ctx_m.dzero ? '0 : (ctx_m.dneg_x ? -qx : qx);
    ay     = ctx_m.dzero ? '0 : (ctx_m.dneg_y ? -qy : qy);
    vsum_x = {{2{ctx_m.vx[15]}}, ctx_m.vx} + ax + ctx_m.jx;
    vsum_y = {{2{ctx_m.vy[15]}}, ctx_m.vy} + ay + ctx_m.jy;
    moving = (ctx_m.mode == MODE_RANDOM) || (ctx_m.mode == MODE_SEEK);
    ctx_d_next.px     = ctx_m.px;
    ctx_d_next.py     = ctx_m.py;
    ctx_d_next.vx     = moving ? vsum_x : {{2{ctx_m.vx[15]}}, ctx_m.vx};
    ctx_d_next.vy     = moving ? vsum_y : {{2{ctx_m.vy[15]}}, ctx_m.vy};
    ctx_d_next.rad    = ctx_m.rad;
    ctx_d_next.alive  = ctx_m.alive;
    ctx_d_next.moving = moving;
    ctx_d_next.limit  = 1'b0;
    ctx_d_next.nx     = '0;
    ctx_d_next.ny     = '0;
  end

  vel_ctx_t ctx_d;
  logic     d_valid;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else d_valid <= div1_valid && div1_valid_y;
    ctx_d <= ctx_d_next;
  end

  // Stage E: speed squares against the squared limit, and the numerators
  // for rescaling to max_speed.
  logic [16:0] vabs_x, vabs_y;
  logic [31:0] lim_x, lim_y;
  vel_ctx_t    ctx_e_next;

  always_comb begin
    vabs_x = ctx_d.vx[17] ? 17'(-ctx_d.vx) : ctx_d.vx[16:0];
    vabs_y = ctx_d.vy[17] ? 17'(-ctx_d.vy) : ctx_d.vy[16:0];
    lim_x  = vabs_x * cfg.max_speed;
    lim_y  = vabs_y * cfg.max_speed;
    ctx_e_next    = ctx_d;
    ctx_e_next.nx = {lim_x, 8'b0};
    ctx_e_next.ny = {lim_y, 8'b0};
  end

  vel_ctx_t    ctx_e;
  logic        e_valid;
  logic [33:0] e_sq_x, e_sq_y;
  logic [29:0] e_max2;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else e_valid <= d_valid;
    ctx_e  <= ctx_e_next;
    e_sq_x <= vabs_x * vabs_x;
    e_sq_y <= vabs_y * vabs_y;
    e_max2 <= cfg.max_speed * cfg.max_speed;
  end

  // Stage F: limit decision and radicand for the speed length.
  logic [34:0]     e_sum;
  vel_ctx_t        ctx_f_next;
  vel_ctx_t        ctx_f;
  logic            f_valid;
  logic [SQ_W-1:0] f_rad;

  assign e_sum = 35'(e_sq_x) + 35'(e_sq_y);

  always_comb begin
    ctx_f_next       = ctx_e;
    ctx_f_next.limit = ctx_e.moving && (e_sum > 35'(e_max2));
  end

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else f_valid <= e_valid;
    ctx_f <= ctx_f_next;
    f_rad <= SQ_W'({e_sum, 16'b0});
  end

  // Speed length, then the two rescaled velocity axes.
  logic              sq2_valid;
  logic [ROOT_W-1:0] sq2_root;
  vel_ctx_t          ctx3_dl [SQRT_LAT];

  pmu_sqrt u_sqrt_speed (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_val    (f_rad),
    .out_valid (sq2_valid),
    .root      (sq2_root)
  );

  always_ff @(posedge clk) begin
    ctx3_dl[0] <= ctx_f;
    for (int k = 1; k < SQRT_LAT; k++) ctx3_dl[k] <= ctx3_dl[k-1];
  end

  logic               div2_valid;
  logic               div2_valid_y;
  logic [DIV_LAT-1:0] q2_x, q2_y;
  vel_ctx_t           ctx4_dl [DIV_LAT];

  pmu_div u_div_speed_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq2_valid),
    .num       (ctx3_dl[SQRT_LAT-1].nx),
    .den       (sq2_root),
    .out_valid (div2_valid),
    .quot      (q2_x)
  );

  pmu_div u_div_speed_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq2_valid),
    .num       (ctx3_dl[SQRT_LAT-1].ny),
    .den       (sq2_root),
    .out_valid (div2_valid_y),
    .quot      (q2_y)
  );

  always_ff @(posedge clk) begin
    ctx4_dl[0] <= ctx3_dl[SQRT_LAT-1];
    for (int k = 1; k < DIV_LAT; k++) ctx4_dl[k] <= ctx4_dl[k-1];
  end

  // Stage G: apply the limit when it fired and saturate the velocity.
  vel_ctx_t    ctx_l;
  logic [17:0] lq_x, lq_y, vl_x, vl_y;

  always_comb begin
    ctx_l = ctx4_dl[DIV_LAT-1];
    lq_x  = {1'b0, q2_x};
    lq_y  = {1'b0, q2_y};
    vl_x  = ctx_l.limit ? (ctx_l.vx[17] ? -lq_x : lq_x) : ctx_l.vx;
    vl_y  = ctx_l.limit ? (ctx_l.vy[17] ? -lq_y : lq_y) : ctx_l.vy;
  end

  edge_in_t g_item;
  logic     g_valid;
  logic     g_moving;

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else g_valid <= div2_valid && div2_valid_y;
    g_item.px    <= {ctx_l.px[15], ctx_l.px};
    g_item.py    <= {ctx_l.py[15], ctx_l.py};
    g_item.vx    <= sat16({vl_x[17], vl_x});
    g_item.vy    <= sat16({vl_y[17], vl_y});
    g_item.rad   <= ctx_l.rad;
    g_item.alive <= ctx_l.alive;
    g_moving     <= ctx_l.moving;
  end

  // Stage H: position step, the velocity in Q8.8 rounded toward minus
  // infinity (an arithmetic shift by eight).
  logic [16:0] step_x, step_y;
  edge_in_t    h_item_next;
  edge_in_t    h_item;
  logic        h_valid;

  always_comb begin
    step_x = g_moving ? {{9{g_item.vx[15]}}, g_item.vx[15:8]} : '0;
    step_y = g_moving ? {{9{g_item.vy[15]}}, g_item.vy[15:8]} : '0;
    h_item_next    = g_item;
    h_item_next.px = g_item.px + step_x;
    h_item_next.py = g_item.py + step_y;
  end

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else h_valid <= g_valid;
    h_item <= h_item_next;
  end

  // Edge handling and the output register.
  pmu_edge u_edge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (h_valid),
    .in_item  (h_item),
    .cfg      (cfg),
    .done     (done),
    .result   (result)
  );

endmodule
